/* rtl/bmos_pkg.sv */
// ============================================================================
// bmos_pkg: shared types and constants of the box mean outlier filter
// Pixel, column and line buffer types, register codes and fixed constants.
// ============================================================================
package bmos_pkg;

    // Pixel and sum widths
    localparam int PIX_W      = 8;
    localparam int COL_SUM_W  = 10;   // three pixels
    localparam int WIN_SUM_W  = 12;   // nine pixels
    localparam int WIN_SIZE   = 9;

    // Divide by nine as a multiply by 3641 / 2^15; exact for sums up to 2295.
    localparam int RECIP_W     = 12;
    localparam int RECIP_SHIFT = 15;
    localparam logic [RECIP_W-1:0] RECIP_NINE = 12'd3641;

    // Configuration register widths and limits
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int LIMIT_REG_W  = 8;
    localparam int ROW_W        = 12;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MIN_DIM      = 3;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [LIMIT_REG_W-1:0]  LIMIT_RESET  = 8'd50;

    localparam int MAX_WIDTH_DEF = 1024;

    // Register port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_DEV_LIMIT    = 2'd2
    } t_reg_idx;

    // One window column, oldest row on top
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_pix_col;

    // One line buffer entry: the pixel two rows up and the one a row up
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
    } t_line_pair;

endpackage

/* rtl/bmos_col_cell.sv */
// ============================================================================
// bmos_col_cell: one column of the 3x3 window
// Holds three pixels and their sum, and passes them to the older neighbor.
// ============================================================================
module bmos_col_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  bmos_pkg::t_pix_col         i_col,
    output bmos_pkg::t_pix_col         o_col,
    output logic [bmos_pkg::COL_SUM_W-1:0] o_sum
);
    import bmos_pkg::*;

    t_pix_col               r_col;
    logic [COL_SUM_W-1:0]   r_sum;
    logic [COL_SUM_W-1:0]   n_sum;

    // Column sum of the incoming pixels, stored with them.
    assign n_sum = COL_SUM_W'(i_col.top) + COL_SUM_W'(i_col.mid) + COL_SUM_W'(i_col.bot);

    // Shift the column in whenever the window moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_sum <= '0;
        end else if (i_en) begin
            r_col <= i_col;
            r_sum <= n_sum;
        end
    end

    assign o_col = r_col;
    assign o_sum = r_sum;

endmodule

/* rtl/bmos_line_buf.sv */
// ============================================================================
// bmos_line_buf: two-row line buffer
// One entry per column holds the two prior rows; registered read with a
// bypass when the same entry is written in the read cycle.
// ============================================================================
module bmos_line_buf #(
    parameter int MAX_WIDTH = bmos_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_wr_addr,
    input  bmos_pkg::t_line_pair          i_wr_data,
    output bmos_pkg::t_line_pair          o_rd_data
);
    import bmos_pkg::*;

    t_line_pair mem [MAX_WIDTH];
    t_line_pair r_rd;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; a write to the same entry in this cycle is passed through.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else begin
                r_rd <= mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

/* rtl/box_mean_outlier_suppress.sv */
// A result word passes the line buffer stage, the window cells, the window
// stage and the output register after the edge that accepts the word completing
// its window, which is image_width+1 words after its centre pixel. Throughput:
// one word per cycle while the output is not stalled.
// Reset (synchronous, active low) clears counters, window, valid flags and
// configuration registers to defaults; the line buffer is not cleared.
// ============================================================================
// box_mean_outlier_suppress: 3x3 box mean outlier suppression
// Raster pixel stream in, filtered stream out; border and outlier pixels
// give zero. Configured through a small register port.
// ============================================================================
module box_mean_outlier_suppress #(
    parameter int MAX_WIDTH = bmos_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input pixel channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bmos_pkg::PIX_W-1:0]        i_pixel_in,
    input  logic                              i_frame_start,
    input  logic                              i_flush,
    // Output pixel channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bmos_pkg::PIX_W-1:0]        o_pixel_out,
    output logic                              o_frame_end,
    // Register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bmos_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bmos_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bmos_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import bmos_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CNT_W = $clog2(MAX_WIDTH + 2);
    localparam int CMP_W = (CNT_W > WIDTH_REG_W) ? CNT_W : WIDTH_REG_W;
    localparam int PROD_W = WIN_SUM_W + RECIP_W;

    typedef struct packed {
        logic emit;
        logic inner;
        logic last;
    } t_meta;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_REG_W-1:0]  r_image_width;
    logic [HEIGHT_REG_W-1:0] r_image_height;
    logic [LIMIT_REG_W-1:0]  r_dev_limit;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
            r_dev_limit    <= LIMIT_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[HEIGHT_REG_W-1:0];
                REG_DEV_LIMIT:    r_dev_limit    <= pwdata[LIMIT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_image_height);
            REG_DEV_LIMIT:    prdata = APB_DATA_W'(r_dev_limit);
            default:          prdata = '0;
        endcase
    end

    // Effective frame size, clamped to the supported range.
    logic [CMP_W-1:0]        width_ext;
    logic [CNT_W-1:0]        eff_w;
    logic [HEIGHT_REG_W-1:0] eff_h;

    always_comb begin
        width_ext = CMP_W'(r_image_width);
        if (width_ext < CMP_W'(MIN_DIM)) begin
            width_ext = CMP_W'(MIN_DIM);
        end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
            width_ext = CMP_W'(MAX_WIDTH);
        end
        eff_w = width_ext[CNT_W-1:0];
        if (r_image_height < HEIGHT_REG_W'(MIN_DIM)) begin
            eff_h = HEIGHT_REG_W'(MIN_DIM);
        end else if (r_image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            eff_h = HEIGHT_REG_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_image_height;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless a result is held back.
    // ------------------------------------------------------------------
    logic adv;
    logic accept;

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;
    assign accept  = i_valid && adv;

    // ------------------------------------------------------------------
    // Front stage: position counters and result bookkeeping
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_cnt;
    logic [AW-1:0]    r_in_col;
    logic [AW-1:0]    r_ccol;
    logic [ROW_W-1:0] r_crow;
    logic             r_done;

    logic [CNT_W-1:0] cnt_cur;
    logic [AW-1:0]    in_col_cur;
    logic [AW-1:0]    ccol_cur;
    logic [ROW_W-1:0] crow_cur;
    logic             done_cur;
    logic [AW-1:0]    s0_col;
    logic [AW-1:0]    s0_col_next;
    logic [AW-1:0]    cc;
    logic             priming;
    t_meta            s0_meta;
    logic [PIX_W-1:0] s0_px;

    always_comb begin
        // A frame start restarts every position counter.
        cnt_cur    = i_frame_start ? '0 : r_cnt;
        in_col_cur = i_frame_start ? '0 : r_in_col;
        ccol_cur   = i_frame_start ? '0 : r_ccol;
        crow_cur   = i_frame_start ? '0 : r_crow;
        done_cur   = i_frame_start ? 1'b0 : r_done;

        // Flush words enter as zero pixels.
        s0_px = (i_flush && !i_frame_start) ? '0 : i_pixel_in;

        s0_col      = (CNT_W'(in_col_cur) >= eff_w) ? '0 : in_col_cur;
        s0_col_next = (CNT_W'(s0_col) + CNT_W'(1) >= eff_w) ? '0 : s0_col + AW'(1);

        priming = cnt_cur < eff_w + CNT_W'(1);
        cc      = (CNT_W'(ccol_cur) >= eff_w) ? '0 : ccol_cur;

        s0_meta.emit  = !priming && !done_cur;
        s0_meta.inner = (cc != '0) && (CNT_W'(cc) + CNT_W'(2) <= eff_w) &&
                        (crow_cur != '0) &&
                        (HEIGHT_REG_W'(crow_cur) + HEIGHT_REG_W'(2) <= eff_h);
        s0_meta.last  = (HEIGHT_REG_W'(crow_cur) + HEIGHT_REG_W'(1) >= eff_h) &&
                        (CNT_W'(cc) + CNT_W'(1) >= eff_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_in_col <= '0;
            r_ccol   <= '0;
            r_crow   <= '0;
            r_done   <= 1'b0;
        end else if (accept) begin
            r_in_col <= s0_col_next;
            r_cnt    <= priming ? cnt_cur + CNT_W'(1) : cnt_cur;
            if (s0_meta.emit && s0_meta.last) begin
                r_done <= 1'b1;
                r_ccol <= cc;
                r_crow <= crow_cur;
            end else if (s0_meta.emit && (CNT_W'(cc) + CNT_W'(1) >= eff_w)) begin
                r_done <= done_cur;
                r_ccol <= '0;
                r_crow <= crow_cur + ROW_W'(1);
            end else if (s0_meta.emit) begin
                r_done <= done_cur;
                r_ccol <= cc + AW'(1);
                r_crow <= crow_cur;
            end else begin
                r_done <= done_cur;
                r_ccol <= ccol_cur;
                r_crow <= crow_cur;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line buffer stage: read the column entry, write back the shifted rows
    // ------------------------------------------------------------------
    logic             r_b_valid;
    t_meta            r_b_meta;
    logic [PIX_W-1:0] r_b_px;
    logic [AW-1:0]    r_b_col;
    t_line_pair       lb_rd;
    t_line_pair       lb_wr;
    t_pix_col         new_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_meta  <= '0;
        end else if (adv) begin
            r_b_valid <= accept;
            r_b_meta  <= accept ? s0_meta : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_px  <= s0_px;
            r_b_col <= s0_col;
        end
    end

    assign lb_wr.top   = lb_rd.mid;
    assign lb_wr.mid   = r_b_px;
    assign new_col.top = lb_rd.top;
    assign new_col.mid = lb_rd.mid;
    assign new_col.bot = r_b_px;

    bmos_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (adv),
        .i_rd_addr (s0_col),
        .i_wr_en   (adv && r_b_valid),
        .i_wr_addr (r_b_col),
        .i_wr_data (lb_wr),
        .o_rd_data (lb_rd)
    );

    // ------------------------------------------------------------------
    // Window: three column cells, newest column first
    // ------------------------------------------------------------------
    logic                 win_en;
    t_pix_col             cell_col [3];
    logic [COL_SUM_W-1:0] cell_sum [3];

    assign win_en = adv && r_b_valid;

    bmos_col_cell u_cell_new (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (win_en),
        .i_col   (new_col),
        .o_col   (cell_col[2]),
        .o_sum   (cell_sum[2])
    );

    bmos_col_cell u_cell_ctr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (win_en),
        .i_col   (cell_col[2]),
        .o_col   (cell_col[1]),
        .o_sum   (cell_sum[1])
    );

    bmos_col_cell u_cell_old (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (win_en),
        .i_col   (cell_col[1]),
        .o_col   (cell_col[0]),
        .o_sum   (cell_sum[0])
    );

    // ------------------------------------------------------------------
    // Window stage: total the column sums and keep the centre pixel
    // ------------------------------------------------------------------
    t_meta                r_c_meta;
    t_meta                r_d_meta;
    logic [WIN_SUM_W-1:0] r_d_sum;
    logic [PIX_W-1:0]     r_d_ctr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_meta <= '0;
            r_d_meta <= '0;
        end else if (adv) begin
            r_c_meta <= r_b_meta;
            r_d_meta <= r_c_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_sum <= WIN_SUM_W'(cell_sum[0]) + WIN_SUM_W'(cell_sum[1]) +
                       WIN_SUM_W'(cell_sum[2]);
            r_d_ctr <= cell_col[1].mid;
        end
    end

    // ------------------------------------------------------------------
    // Decision stage: mean by reciprocal multiply, deviation test
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] d_prod;
    logic [PIX_W-1:0]  d_mean;
    logic [PIX_W-1:0]  d_diff;
    logic [PIX_W-1:0]  d_result;

    assign d_prod   = PROD_W'(r_d_sum) * PROD_W'(RECIP_NINE);
    assign d_mean   = d_prod[RECIP_SHIFT +: PIX_W];
    assign d_diff   = (d_mean > r_d_ctr) ? d_mean - r_d_ctr : r_d_ctr - d_mean;
    assign d_result = (r_d_meta.inner && (d_diff <= r_dev_limit)) ? r_d_ctr : '0;

    // Output register.
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_d_meta.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_pixel <= d_result;
            r_out_end   <= r_d_meta.last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pixel;
    assign o_frame_end = r_out_end;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    // The reciprocal multiply gives the truncated mean of an interior window.
    a_mean_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_meta.emit && r_d_meta.inner) |->
            ((WIN_SUM_W'(d_mean) * WIN_SUM_W'(WIN_SIZE) <= r_d_sum) &&
             (r_d_sum < WIN_SUM_W'(d_mean) * WIN_SUM_W'(WIN_SIZE) + WIN_SUM_W'(WIN_SIZE))))
        else $error("window mean out of range");

    // A border result that moves to the output is zero.
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_d_meta.emit && !r_d_meta.inner) |=> (o_pixel_out == '0))
        else $error("border pixel not suppressed");

    // The line buffer is always addressed inside the active row.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (CNT_W'(s0_col) < eff_w))
        else $error("line buffer column beyond image width");

    // An accepted word reaches the line buffer stage on the next edge.
    a_word_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_b_valid)
        else $error("accepted word lost before line buffer");
`endif

endmodule
